// ----- rtl/core/rgbk_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbk_pkg
// Types, register indexes and Q-format kernel coefficients shared by the
// RGB 3x3 convolution filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbk_pkg;

  localparam int COEF_FRAC_BITS = 12;
  localparam int COEF_W         = COEF_FRAC_BITS + 5;
  localparam int PROD_W         = COEF_W + 9;
  localparam int RS_W           = PROD_W + 2;
  localparam int ACC_W          = PROD_W + 4;
  localparam int MAX_HEIGHT     = 4096;
  localparam int NUM_KERNELS    = 5;
  localparam int NUM_TAPS       = 9;

  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_IDX_KERNEL = 2'd2;

  localparam logic [2:0] KERN_SMOOTH  = 3'd0;
  localparam logic [2:0] KERN_BLUR    = 3'd1;
  localparam logic [2:0] KERN_SHARPEN = 3'd2;
  localparam logic [2:0] KERN_MEAN    = 3'd3;
  localparam logic [2:0] KERN_EMBOSS  = 3'd4;

  localparam int ONE_Q    = 1 << COEF_FRAC_BITS;
  localparam int C_NINTH  = (2 * ONE_Q + 9) / 18;
  localparam int C_SIXT1  = (ONE_Q + 8) / 16;
  localparam int C_SIXT2  = (2 * ONE_Q + 8) / 16;
  localparam int C_SIXT4  = (4 * ONE_Q + 8) / 16;
  localparam int C_SHSIDE = -((4 * ONE_Q + 3) / 6);
  localparam int C_SHMID  = (22 * ONE_Q + 3) / 6;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t KERNEL_COEF [NUM_KERNELS][NUM_TAPS] = '{
    '{coef_t'(C_NINTH), coef_t'(C_NINTH), coef_t'(C_NINTH),
      coef_t'(C_NINTH), coef_t'(C_NINTH), coef_t'(C_NINTH),
      coef_t'(C_NINTH), coef_t'(C_NINTH), coef_t'(C_NINTH)},
    '{coef_t'(C_SIXT1), coef_t'(C_SIXT2), coef_t'(C_SIXT1),
      coef_t'(C_SIXT2), coef_t'(C_SIXT4), coef_t'(C_SIXT2),
      coef_t'(C_SIXT1), coef_t'(C_SIXT2), coef_t'(C_SIXT1)},
    '{coef_t'(0), coef_t'(C_SHSIDE), coef_t'(0),
      coef_t'(C_SHSIDE), coef_t'(C_SHMID), coef_t'(C_SHSIDE),
      coef_t'(0), coef_t'(C_SHSIDE), coef_t'(0)},
    '{coef_t'(-ONE_Q), coef_t'(-ONE_Q), coef_t'(-ONE_Q),
      coef_t'(-ONE_Q), coef_t'(9 * ONE_Q), coef_t'(-ONE_Q),
      coef_t'(-ONE_Q), coef_t'(-ONE_Q), coef_t'(-ONE_Q)},
    '{coef_t'(0), coef_t'(ONE_Q), coef_t'(0),
      coef_t'(0), coef_t'(0), coef_t'(0),
      coef_t'(0), coef_t'(-ONE_Q), coef_t'(0)}
  };

  // [2] red, [1] green, [0] blue
  typedef logic [2:0][7:0] pix_t;
  typedef logic [8:0][2:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_req_t;

  typedef struct packed {
    logic [11:0] out_col;
    logic [11:0] out_row;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        last_of_run;
  } out_req_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_rsum;
    logic ld_res;
  } filt_ctl_t;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    pix_t        px;
    logic        filt;
    logic        pass;
  } meta_t;

endpackage

`default_nettype wire

// ----- rtl/core/rgbk_ram.sv -----
// ----------------------------------------------------------------------------
// rgbk_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbk_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/rgbk_filter.sv -----
// ----------------------------------------------------------------------------
// rgbk_filter
// Three-stage kernel datapath: tap products, row sums, then total with
// clamp to 0..255. Unused kernel codes pass the window centre.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbk_filter (
  input  wire logic                clk,
  input  wire rgbk_pkg::filt_ctl_t ctl,
  input  wire logic [2:0]          kernel_sel,
  input  wire rgbk_pkg::win_t      window,
  output rgbk_pkg::pix_t           result
);

  localparam int PROD_W = rgbk_pkg::PROD_W;
  localparam int RS_W   = rgbk_pkg::RS_W;
  localparam int ACC_W  = rgbk_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(255);

  rgbk_pkg::coef_t         coef [rgbk_pkg::NUM_TAPS];
  logic signed [PROD_W-1:0] prod_r [3][rgbk_pkg::NUM_TAPS];
  logic signed [RS_W-1:0]   rsum_r [3][3];
  rgbk_pkg::pix_t           cen3_r;
  rgbk_pkg::pix_t           cen4_r;
  rgbk_pkg::pix_t           res_nxt;
  rgbk_pkg::pix_t           res_r;
  logic signed [ACC_W-1:0]  total [3];
  logic signed [ACC_W-1:0]  shifted [3];

  always_comb begin
    for (int k = 0; k < rgbk_pkg::NUM_TAPS; k++) begin
      if (kernel_sel <= rgbk_pkg::KERN_EMBOSS) begin
        coef[k] = rgbk_pkg::KERNEL_COEF[kernel_sel][k];
      end else begin
        coef[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      cen3_r <= window[4];
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < rgbk_pkg::NUM_TAPS; k++) begin
          prod_r[ch][k] <= PROD_W'(coef[k]) * PROD_W'($signed({1'b0, window[k][ch]}));
        end
      end
    end
    if (ctl.ld_rsum) begin
      cen4_r <= cen3_r;
      for (int ch = 0; ch < 3; ch++) begin
        for (int row = 0; row < 3; row++) begin
          rsum_r[ch][row] <= RS_W'(prod_r[ch][3*row]) + RS_W'(prod_r[ch][3*row+1])
                           + RS_W'(prod_r[ch][3*row+2]);
        end
      end
    end
    if (ctl.ld_res) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total[ch]   = ACC_W'(rsum_r[ch][0]) + ACC_W'(rsum_r[ch][1]) + ACC_W'(rsum_r[ch][2]);
      shifted[ch] = total[ch] >>> rgbk_pkg::COEF_FRAC_BITS;
      if (kernel_sel > rgbk_pkg::KERN_EMBOSS) begin
        res_nxt[ch] = cen4_r[ch];
      end else if (total[ch] <= 0) begin
        res_nxt[ch] = 8'd0;
      end else if (shifted[ch] > SAT_MAX) begin
        res_nxt[ch] = 8'd255;
      end else begin
        res_nxt[ch] = shifted[ch][7:0];
      end
    end
  end

  assign result = res_r;

endmodule

`default_nettype wire

// ----- rtl/core/rgb_3x3_kernel_convolution.sv -----
// ----------------------------------------------------------------------------
// rgb_3x3_kernel_convolution
// A request's first result is offered after its window, product, row-sum and
// result registers. Throughput: one pixel per cycle without output stall, set
// by each line store's port pair; a two-result pixel holds the output stage
// until both go. Reset: counters, window and pipeline cleared, width 640, height
// 480, smooth kernel; line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_3x3_kernel_convolution #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rgbk_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rgbk_pkg::out_req_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int NSTG  = 5;

  logic [12:0]         image_width_r;
  logic [12:0]         image_height_r;
  logic [2:0]          kernel_select_r;
  logic [COL_W-1:0]    col_r;
  logic [COL_W-1:0]    col_nxt;
  logic [11:0]         row_r;
  logic [11:0]         row_nxt;
  logic [COL_W-1:0]    addr1_r;
  logic [13:0]         wm1;
  logic [12:0]         hm1;
  logic                last_col;
  logic                last_row;
  logic                in_fire;
  logic                out_fire;
  logic                out_split;
  logic                out_done;
  logic [NSTG-1:0]     v_r;
  logic [NSTG-1:0]     en;
  rgbk_pkg::meta_t     meta_r [NSTG];
  rgbk_pkg::meta_t     meta_in;
  rgbk_pkg::pix_t      px_in;
  rgbk_pkg::pix_t      upper_rd;
  rgbk_pkg::pix_t      middle_rd;
  rgbk_pkg::win_t      window_r;
  rgbk_pkg::pix_t      filt_px;
  rgbk_pkg::filt_ctl_t filt_ctl;
  logic                wb_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= 13'd640;
      image_height_r  <= 13'd480;
      kernel_select_r <= rgbk_pkg::KERN_SMOOTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        rgbk_pkg::CFG_IDX_WIDTH:  image_width_r   <= cfg_data;
        rgbk_pkg::CFG_IDX_HEIGHT: image_height_r  <= cfg_data;
        rgbk_pkg::CFG_IDX_KERNEL: kernel_select_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width_r < 13'd3) begin
      wm1 = 14'd2;
    end else if (14'(image_width_r) > 14'(MAX_WIDTH)) begin
      wm1 = 14'(MAX_WIDTH - 1);
    end else begin
      wm1 = 14'(image_width_r) - 14'd1;
    end
    if (image_height_r < 13'd3) begin
      hm1 = 13'd2;
    end else if (image_height_r > 13'(rgbk_pkg::MAX_HEIGHT)) begin
      hm1 = 13'(rgbk_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = image_height_r - 13'd1;
    end
  end

  assign last_col = 14'(col_r) >= wm1;
  assign last_row = 13'(row_r) >= hm1;
  assign px_in    = {in_data.in_red, in_data.in_green, in_data.in_blue};

  always_comb begin
    meta_in.col  = 12'(col_r);
    meta_in.row  = row_r;
    meta_in.px   = px_in;
    meta_in.filt = (col_r >= COL_W'(2)) && (row_r >= 12'd2);
    meta_in.pass = (col_r == '0) || (row_r == '0) || last_col || last_row;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? 12'd0 : row_r + 12'd1;
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  assign out_fire  = out_valid && !out_stall;
  assign out_split = meta_r[NSTG-1].filt && meta_r[NSTG-1].pass;
  assign out_done  = out_fire && !out_split;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_done;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];
  assign in_fire  = in_valid && en[0];
  assign wb_en    = v_r[0] && en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_fire;
      end
      if (en[1]) begin
        v_r[1] <= v_r[0] && (meta_r[0].filt || meta_r[0].pass);
      end
      for (int i = 2; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      meta_r[0] <= meta_in;
      addr1_r   <= col_r;
    end
    for (int i = 1; i < NSTG - 1; i++) begin
      if (en[i]) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
    if (en[NSTG-1]) begin
      meta_r[NSTG-1] <= meta_r[NSTG-2];
    end else if (out_fire && out_split) begin
      meta_r[NSTG-1].filt <= 1'b0;
    end
  end

  // Consecutive pixels never share a column, so the write-back of one pixel
  // cannot collide with the read of the next.
  rgbk_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (wb_en),
    .waddr (addr1_r),
    .wdata (middle_rd),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (upper_rd)
  );

  rgbk_ram #(
    .WIDTH (24),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (wb_en),
    .waddr (addr1_r),
    .wdata (meta_r[0].px),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (middle_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (wb_en) begin
      window_r[0] <= window_r[1];
      window_r[1] <= window_r[2];
      window_r[2] <= upper_rd;
      window_r[3] <= window_r[4];
      window_r[4] <= window_r[5];
      window_r[5] <= middle_rd;
      window_r[6] <= window_r[7];
      window_r[7] <= window_r[8];
      window_r[8] <= meta_r[0].px;
    end
  end

  assign filt_ctl.ld_prod = en[2];
  assign filt_ctl.ld_rsum = en[3];
  assign filt_ctl.ld_res  = en[4];

  rgbk_filter u_filter (
    .clk        (clk),
    .ctl        (filt_ctl),
    .kernel_sel (kernel_select_r),
    .window     (window_r),
    .result     (filt_px)
  );

  assign out_valid = v_r[NSTG-1];

  always_comb begin
    if (meta_r[NSTG-1].filt) begin
      out_data.out_col     = meta_r[NSTG-1].col - 12'd1;
      out_data.out_row     = meta_r[NSTG-1].row - 12'd1;
      out_data.out_red     = filt_px[2];
      out_data.out_green   = filt_px[1];
      out_data.out_blue    = filt_px[0];
      out_data.last_of_run = !meta_r[NSTG-1].pass;
    end else begin
      out_data.out_col     = meta_r[NSTG-1].col;
      out_data.out_row     = meta_r[NSTG-1].row;
      out_data.out_red     = meta_r[NSTG-1].px[2];
      out_data.out_green   = meta_r[NSTG-1].px[1];
      out_data.out_blue    = meta_r[NSTG-1].px[0];
      out_data.last_of_run = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rgbk_checker.sv -----
// ----------------------------------------------------------------------------
// rgbk_checker
// Port-level checks on the convolution filter's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbk_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire rgbk_pkg::out_req_t out_data
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result request changed");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_of_run |=> out_valid && out_data.last_of_run)
    else $error("filtered result not followed by its pass-through");

  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> out_data.out_col != 12'd0 &&
                                           out_data.out_row != 12'd0)
    else $error("filtered result on a border coordinate");

endmodule

bind rgb_3x3_kernel_convolution rgbk_checker u_rgbk_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_rgb_3x3_kernel_convolution.sv -----
// ----------------------------------------------------------------------------
// tb_rgb_3x3_kernel_convolution
// Streams RGB pixels through the 3x3 convolution filter under random idle
// and stall patterns, predicts every border and filtered pixel with a local
// line-store and window model, and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb_3x3_kernel_convolution;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_COLS       = 4096;
  localparam int          MAX_ROWS       = 4096;
  localparam int          FRAC           = rgbk_pkg::COEF_FRAC_BITS;
  localparam int          Q_ONE          = 1 << FRAC;
  localparam int          W_NINTH        = (2 * Q_ONE + 9) / 18;
  localparam int          W_SIXTEENTH    = (Q_ONE + 8) / 16;
  localparam int          W_EIGHTH       = (2 * Q_ONE + 8) / 16;
  localparam int          W_QUARTER      = (4 * Q_ONE + 8) / 16;
  localparam int          W_SHARP_SIDE   = -((4 * Q_ONE + 3) / 6);
  localparam int          W_SHARP_MID    = (22 * Q_ONE + 3) / 6;
  localparam logic [1:0]  CFG_IDX_SPARE  = 2'd3;
  localparam logic [11:0] SHARP_SPOTS    = 12'h424;
  localparam int          RANDOM_PIXELS  = 950;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          TAIL_CYCLES    = 20;
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_NEAR_RAIL} texture_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  rgbk_pkg::in_req_t    in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rgbk_pkg::out_req_t   out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [12:0]          cfg_data = '0;

  rgb_3x3_kernel_convolution uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  rgbk_pkg::pix_t row_minus2 [MAX_COLS] = '{default: '0};
  rgbk_pkg::pix_t row_minus1 [MAX_COLS] = '{default: '0};
  rgbk_pkg::pix_t taps [9]              = '{default: '0};
  int unsigned    pos_col               = 0;
  int unsigned    pos_row               = 0;
  logic [12:0]    img_w                 = 13'd640;
  logic [12:0]    img_h                 = 13'd480;
  logic [2:0]     kern_sel              = rgbk_pkg::KERN_SMOOTH;

  rgbk_pkg::in_req_t  pixel_q [$];
  rgbk_pkg::out_req_t due_pixels [$];
  int       mismatches  = 0;
  int       send_gap    = 0;
  int       stall_left  = 0;
  int       idle_cycles = 0;
  bit       calm_sender   = 1'b0;
  bit       calm_receiver = 1'b0;

  function automatic int tap_weight(logic [2:0] kern, int k);
    case (kern)
      rgbk_pkg::KERN_SMOOTH:  return W_NINTH;
      rgbk_pkg::KERN_BLUR:
        return (k == 4) ? W_QUARTER : (k % 2 == 1) ? W_EIGHTH : W_SIXTEENTH;
      rgbk_pkg::KERN_SHARPEN:
        return (k == 4) ? W_SHARP_MID : (k % 2 == 1) ? W_SHARP_SIDE : 0;
      rgbk_pkg::KERN_MEAN:    return (k == 4) ? 9 * Q_ONE : -Q_ONE;
      rgbk_pkg::KERN_EMBOSS:  return (k == 1) ? Q_ONE : (k == 7) ? -Q_ONE : 0;
      default:                return 0;
    endcase
  endfunction

  function automatic logic [7:0] filter_channel(int ch);
    longint acc;
    longint q;
    int     k;
    acc = 0;
    if (kern_sel > rgbk_pkg::KERN_EMBOSS) return taps[4][ch];
    for (k = 0; k < 9; k++) begin
      acc += longint'(tap_weight(kern_sel, k)) * longint'(taps[k][ch]);
    end
    if (acc <= 0) return 8'd0;
    q = acc >>> FRAC;
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  function automatic void filter_pixel(rgbk_pkg::in_req_t px_in);
    int unsigned        w;
    int unsigned        h;
    int unsigned        c;
    int unsigned        r;
    rgbk_pkg::pix_t     px;
    rgbk_pkg::pix_t     above;
    rgbk_pkg::out_req_t filt_res;
    rgbk_pkg::out_req_t pass_res;
    bit                 has_filt;
    bit                 has_pass;
    bit                 last_col;
    bit                 last_row;
    w = (img_w < 3) ? 3 : (img_w > MAX_COLS) ? MAX_COLS : img_w;
    h = (img_h < 3) ? 3 : (img_h > MAX_ROWS) ? MAX_ROWS : img_h;
    c = pos_col % MAX_COLS;
    r = pos_row;
    px = {px_in.in_red, px_in.in_green, px_in.in_blue};
    above = row_minus1[c];
    taps[0] = taps[1];
    taps[1] = taps[2];
    taps[3] = taps[4];
    taps[4] = taps[5];
    taps[6] = taps[7];
    taps[7] = taps[8];
    taps[2] = row_minus2[c];
    taps[5] = above;
    taps[8] = px;
    row_minus2[c] = above;
    row_minus1[c] = px;
    last_col = (c >= w - 1);
    last_row = (r >= h - 1);
    has_filt = (c >= 2) && (r >= 2);
    has_pass = (c == 0) || (r == 0) || last_col || last_row;
    filt_res = '{out_col: 12'(c - 1), out_row: 12'(r - 1), out_red: filter_channel(2),
                 out_green: filter_channel(1), out_blue: filter_channel(0),
                 last_of_run: !has_pass};
    pass_res = '{out_col: 12'(c), out_row: 12'(r), out_red: px[2], out_green: px[1],
                 out_blue: px[0], last_of_run: 1'b1};
    if (has_filt) due_pixels.push_back(filt_res);
    if (has_pass) due_pixels.push_back(pass_res);
    if (last_col) begin
      pos_col = 0;
      pos_row = last_row ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endfunction

  function automatic void set_reg(logic [1:0] idx, logic [12:0] val);
    case (idx)
      rgbk_pkg::CFG_IDX_WIDTH:  img_w = val;
      rgbk_pkg::CFG_IDX_HEIGHT: img_h = val;
      rgbk_pkg::CFG_IDX_KERNEL: kern_sel = val[2:0];
      default: ;
    endcase
  endfunction

  function automatic int pick_pause(bit calm, int long_max);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, long_max);
  endfunction

  function automatic logic [7:0] pick_level(texture_t tex);
    case (tex)
      TEXTURE_NOISE:  return 8'($urandom_range(0, 255));
      TEXTURE_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return $urandom_range(0, 1) ? 8'($urandom_range(240, 255))
                                          : 8'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic void queue_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    rgbk_pkg::in_req_t p;
    p.in_red = red;
    p.in_green = green;
    p.in_blue = blue;
    pixel_q.push_back(p);
  endfunction

  function automatic void queue_texture(texture_t tex, int count);
    int i;
    for (i = 0; i < count; i++) begin
      queue_pixel(pick_level(tex), pick_level(tex), pick_level(tex));
    end
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_reg(idx, val);
  endtask

  task automatic settle();
    while (pixel_q.size() != 0 || in_valid || due_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) filter_pixel(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_data  <= pixel_q.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_pause(calm_sender, 40);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rgbk_pkg::out_req_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_pixels.size() == 0) begin
          $error("result at col %0d row %0d with none expected",
                 out_data.out_col, out_data.out_row);
          mismatches++;
        end else begin
          want = due_pixels.pop_front();
          check_field("out_col", want.out_col, out_data.out_col);
          check_field("out_row", want.out_row, out_data.out_row);
          check_field("out_red", 12'(want.out_red), 12'(out_data.out_red));
          check_field("out_green", 12'(want.out_green), 12'(out_data.out_green));
          check_field("out_blue", 12'(want.out_blue), 12'(out_data.out_blue));
          check_field("last_of_run", 12'(want.last_of_run), 12'(out_data.last_of_run));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_pause(calm_receiver, 30);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int          i;
    int          sent;
    int          count;
    int unsigned roll;
    int unsigned w_eff;
    int unsigned h_eff;
    logic [12:0] w_reg;
    logic [12:0] h_reg;
    logic [2:0]  k_reg;
    bit          lit;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // smooth on a flat white frame: 1/9 rounds down, center lands on 254
    write_reg(rgbk_pkg::CFG_IDX_WIDTH, 13'd3);
    write_reg(rgbk_pkg::CFG_IDX_HEIGHT, 13'd3);
    write_reg(rgbk_pkg::CFG_IDX_KERNEL, 13'(rgbk_pkg::KERN_SMOOTH));
    repeat (9) queue_pixel(8'hFF, 8'hFF, 8'hFF);
    settle();

    // sharpen: one center saturates, the other goes negative and clips to zero
    write_reg(rgbk_pkg::CFG_IDX_WIDTH, 13'd4);
    write_reg(rgbk_pkg::CFG_IDX_KERNEL, 13'(rgbk_pkg::KERN_SHARPEN));
    for (i = 0; i < 12; i++) begin
      lit = SHARP_SPOTS[i];
      queue_pixel(lit ? 8'hFF : 8'h00, lit ? 8'h00 : 8'hFF, 8'h80);
    end
    settle();

    // clamped sizes, unused kernel code, width lowered under the column counter
    write_reg(rgbk_pkg::CFG_IDX_WIDTH, 13'd4096);
    write_reg(rgbk_pkg::CFG_IDX_HEIGHT, 13'd0);
    write_reg(rgbk_pkg::CFG_IDX_KERNEL, 13'd6);
    queue_texture(TEXTURE_NOISE, 4);
    settle();
    write_reg(rgbk_pkg::CFG_IDX_WIDTH, 13'd2);
    queue_texture(TEXTURE_NOISE, 7);
    settle();

    sent = 0;

    // tall frame, then height lowered under the row counter
    write_reg(rgbk_pkg::CFG_IDX_WIDTH, 13'd3);
    write_reg(rgbk_pkg::CFG_IDX_HEIGHT, 13'd8191);
    write_reg(rgbk_pkg::CFG_IDX_KERNEL, 13'($urandom_range(0, 4)));
    queue_texture(TEXTURE_NOISE, 30);
    settle();
    write_reg(rgbk_pkg::CFG_IDX_HEIGHT, 13'd3);
    queue_texture(TEXTURE_NOISE, 3);
    settle();
    sent += 33;

    // full-width pass so every line-store column in use holds real pixels
    write_reg(rgbk_pkg::CFG_IDX_WIDTH, 13'd64);
    queue_texture(TEXTURE_NOISE, 64 * 3);
    settle();
    sent += 64 * 3;

    while (sent < RANDOM_PIXELS) begin
      roll = $urandom_range(0, 99);
      w_reg = (roll < 70) ? 13'($urandom_range(3, 10)) :
              (roll < 95) ? 13'($urandom_range(11, 40)) : 13'($urandom_range(41, 64));
      if ($urandom_range(0, 9) == 0) w_reg = 13'($urandom_range(0, 2));
      roll = $urandom_range(0, 99);
      h_reg = (roll < 75) ? 13'($urandom_range(3, 6)) :
              (roll < 90) ? 13'($urandom_range(7, 12)) : 13'($urandom_range(0, 2));
      k_reg = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      calm_sender   = ($urandom_range(0, 4) == 0);
      calm_receiver = ($urandom_range(0, 4) == 0);

      write_reg(rgbk_pkg::CFG_IDX_WIDTH, w_reg);
      write_reg(rgbk_pkg::CFG_IDX_HEIGHT, h_reg);
      if ($urandom_range(0, 4) == 0) begin
        write_reg(rgbk_pkg::CFG_IDX_KERNEL, {10'($urandom), k_reg});
      end else begin
        write_reg(rgbk_pkg::CFG_IDX_KERNEL, 13'(k_reg));
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_IDX_SPARE, 13'($urandom));

      w_eff = (w_reg < 3) ? 3 : w_reg;
      h_eff = (h_reg < 3) ? 3 : h_reg;
      count = w_eff * h_eff;
      if (count <= 200 && $urandom_range(0, 1) == 1) count = 2 * count;
      // drop out mid-frame now and then; the next settings take over there
      if ($urandom_range(0, 6) == 0) count = $urandom_range(1, w_eff * h_eff * 2 - 1);
      queue_texture(texture_t'($urandom_range(0, 2)), count);
      settle();
      sent += count;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
